@@ src/ehit_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehit_pkg
// Shared types and codes for the ellipse-set hit test.
// ----------------------------------------------------------------------------
package ehit_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned RadiusW  = 23;
  localparam int unsigned StretchW = 16;
  localparam int unsigned MatW     = 24;
  localparam int unsigned IdW      = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // register indexes on the config channel
  localparam logic [CfgIdxW-1:0] REG_MAT_XX  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAT_YX  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAT_XY  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAT_YY  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_Y = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INVERT  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_COVER   = 3'd7;

  // request kinds
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_POINT = 2'd1;
  localparam logic [1:0] MODE_DISC  = 2'd2;

  // one stored bubble
  typedef struct packed {
    logic [CoordW-1:0]   cx;
    logic [CoordW-1:0]   cy;
    logic [RadiusW-1:0]  rad;
    logic [StretchW-1:0] st;
  } bubble_t;

  // world transform
  typedef struct packed {
    logic [MatW-1:0]   mat_xx;
    logic [MatW-1:0]   mat_yx;
    logic [MatW-1:0]   mat_xy;
    logic [MatW-1:0]   mat_yy;
    logic [CoordW-1:0] shift_x;
    logic [CoordW-1:0] shift_y;
  } xform_t;

  // evaluator status back to the controller
  typedef struct packed {
    logic valid;
    logic hit;
    logic busy;
  } eval_res_t;

endpackage

@@ src/ellipse_set_hit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_set_hit_test
// Bubble table held in a rotating chain of cells; tests run the chain once
// through a shared pipelined ellipse evaluator at its tail.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | word
//  s_axis   | in  | s_axis_tvalid/tready   | tuser mode, tdata x,y,radius,stretch
//  m_axis   | out | m_axis_tvalid/tready   | tdata hit,bubble_id,table_full
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Add and unused mode: result word registered at accept, output from ST_FINISH.
// Point/disc test: one full rotation of the chain in ST_SCAN, then the
// 7-stage evaluator drain in ST_DRAIN before ST_FINISH.
// One item in flight; the next word is taken while a result waits on m_axis.
// Reset empties the table and loads the identity transform; no clearing pass.
// A stalled m_axis holds a finished result in its final state.
// ----------------------------------------------------------------------------
module ellipse_set_hit_test #(
  parameter int unsigned MAX_BUBBLES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // x_coord[23:0], y_coord[47:24], radius[70:48],
                                      // stretch[86:71], zero [87]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // hit[0], bubble_id[5:1], table_full[6], zero [7]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [ehit_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ehit_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (MAX_BUBBLES > 1) ? $clog2(MAX_BUBBLES) : 1;
  localparam int unsigned CntW = $clog2(MAX_BUBBLES + 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_BUBBLES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_BUBBLES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  ehit_pkg::xform_t xf_q;
  logic             invert_q, cover_q;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic            inside_q;
  logic [ehit_pkg::CoordW-1:0]  px_q, py_q;
  logic [ehit_pkg::RadiusW-1:0] extra_q;
  logic [6:0]      res_q;
  logic [6:0]      m_data_q;
  logic            m_valid_q;

  ehit_pkg::bubble_t   new_bub;
  ehit_pkg::bubble_t   chain [MAX_BUBBLES];
  ehit_pkg::eval_res_t ev_res;

  logic       s_fire, add_store, shift_en, entry_ok, out_load;
  logic [1:0] mode;
  logic [CntW:0] next_id;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign mode          = s_axis_tuser;
  assign cfg_ready_o   = 1'b1;

  assign new_bub.cx  = s_axis_tdata[23:0];
  assign new_bub.cy  = s_axis_tdata[47:24];
  assign new_bub.rad = s_axis_tdata[70:48];
  assign new_bub.st  = s_axis_tdata[86:71];

  assign add_store = s_fire && (mode == ehit_pkg::MODE_ADD) && (count_q < MaxCnt);
  assign shift_en  = add_store || (state_q == ST_SCAN);
  assign entry_ok  = (state_q == ST_SCAN) && (CntW'(idx_q) < count_q);
  assign next_id   = (CntW + 1)'(count_q) + 1'b1;
  assign out_load  = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready);

  // chain: head takes a new bubble on add, otherwise the tail word (rotation)
  for (genvar i = 0; i < MAX_BUBBLES; i++) begin : g_cell
    ehit_pkg::bubble_t d;
    if (i == 0) begin : g_head
      assign d = add_store ? new_bub : chain[MAX_BUBBLES-1];
    end else begin : g_body
      assign d = chain[i-1];
    end
    ehit_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_en),
      .d_i     (d),
      .q_o     (chain[i])
    );
  end

  ehit_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (entry_ok),
    .bub_i   (chain[MAX_BUBBLES-1]),
    .xf_i    (xf_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .extra_i (extra_q),
    .res_o   (ev_res)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xf_q.mat_xx  <= 24'd65536;
      xf_q.mat_yx  <= '0;
      xf_q.mat_xy  <= '0;
      xf_q.mat_yy  <= 24'd65536;
      xf_q.shift_x <= '0;
      xf_q.shift_y <= '0;
      invert_q     <= 1'b0;
      cover_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ehit_pkg::REG_MAT_XX:  xf_q.mat_xx  <= cfg_data_i;
        ehit_pkg::REG_MAT_YX:  xf_q.mat_yx  <= cfg_data_i;
        ehit_pkg::REG_MAT_XY:  xf_q.mat_xy  <= cfg_data_i;
        ehit_pkg::REG_MAT_YY:  xf_q.mat_yy  <= cfg_data_i;
        ehit_pkg::REG_SHIFT_X: xf_q.shift_x <= cfg_data_i;
        ehit_pkg::REG_SHIFT_Y: xf_q.shift_y <= cfg_data_i;
        ehit_pkg::REG_INVERT:  invert_q     <= cfg_data_i[0];
        ehit_pkg::REG_COVER:   cover_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (mode == ehit_pkg::MODE_POINT || mode == ehit_pkg::MODE_DISC) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN:   if (idx_q == '0) state_d = ST_DRAIN;
      ST_DRAIN:  if (!ev_res.busy) state_d = ST_FINISH;
      ST_FINISH: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      inside_q  <= 1'b0;
      res_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (add_store) begin
        count_q <= count_q + 1'b1;
      end
      if (s_fire) begin
        idx_q    <= LastIdx;
        inside_q <= 1'b0;
        if (mode == ehit_pkg::MODE_ADD) begin
          // word: {table_full, bubble_id, hit}
          res_q <= add_store ? {1'b0, ehit_pkg::IdW'(next_id), 1'b0}
                             : {1'b1, ehit_pkg::IdW'(0), 1'b0};
        end else begin
          res_q <= '0;
        end
      end else begin
        if (state_q == ST_SCAN) begin
          idx_q <= idx_q - 1'b1;
        end
        if (ev_res.valid && ev_res.hit) begin
          inside_q <= 1'b1;
        end
        if (state_q == ST_DRAIN && !ev_res.busy) begin
          res_q <= {6'd0, (cover_q || inside_q) != invert_q};
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // query operands, held through the scan; output data register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      px_q    <= new_bub.cx;
      py_q    <= new_bub.cy;
      extra_q <= (mode == ehit_pkg::MODE_DISC) ? new_bub.rad : '0;
    end
    if (out_load) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("bubble count beyond table size");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_store |=> (count_q == $past(count_q) + 1'b1))
    else $error("stored add did not advance count");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ev_res.busy)
    else $error("new word taken while evaluator busy");

  a_res_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_res.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("evaluator result outside a test");

  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && m_valid_q && !m_axis_tready) |=> state_q == ST_FINISH)
    else $error("result dropped while output stalled");

endmodule

@@ src/ehit_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehit_cell
// One slot of the bubble chain; takes its neighbor's bubble when shifted.
// ----------------------------------------------------------------------------
module ehit_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  ehit_pkg::bubble_t d_i,
  output ehit_pkg::bubble_t q_o
);

  ehit_pkg::bubble_t bub_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      bub_q <= d_i;
    end
  end

  assign q_o = bub_q;

endmodule

@@ src/ehit_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehit_eval
// Seven-stage pipe: maps one bubble centre and tests the query against it.
// ----------------------------------------------------------------------------
module ehit_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  ehit_pkg::bubble_t                bub_i,
  input  ehit_pkg::xform_t                 xf_i,
  input  logic [ehit_pkg::CoordW-1:0]      px_i,
  input  logic [ehit_pkg::CoordW-1:0]      py_i,
  input  logic [ehit_pkg::RadiusW-1:0]     extra_i,
  output ehit_pkg::eval_res_t              res_o
);

  localparam int unsigned CW = ehit_pkg::CoordW;

  logic [7:1] v_q;

  // stage 1
  logic signed [47:0] p_xx_q, p_yx_q, p_xy_q, p_yy_q;
  logic [31:0]        s2_1_q;
  logic [23:0]        r_1_q;
  // stage 2
  logic signed [CW-1:0] cx_q, cy_q;
  logic [31:0]          s2_2_q;
  logic [47:0]          r2_2_q;
  // stage 3
  logic [23:0] adx_q, ady_q;
  logic [31:0] s2_3_q;
  logic [47:0] r2_3_q;
  // stage 4
  logic [47:0] adx2_q, ady2_4_q;
  logic [31:0] s2_4_q;
  logic [47:0] r2_4_q;
  // stage 5
  logic [55:0] lhi_q, llo_q, rhi_q, rlo_q;
  logic [47:0] ady2_5_q;
  // stage 6
  logic [80:0] lhs_q;
  logic [79:0] rhs_q;
  // stage 7
  logic        hit_q;

  // centre mapping: round half up to Q.8, add shift, saturate
  function automatic logic signed [23:0] map_axis(logic signed [47:0] pa,
                                                  logic signed [47:0] pb,
                                                  logic signed [23:0] sh);
    logic signed [49:0] sum;
    logic signed [33:0] rnd;
    logic signed [34:0] tot;
    logic signed [23:0] res;
    sum = 50'(pa) + 50'(pb) + 50'sd32768;
    rnd = sum[49:16];
    tot = 35'(rnd) + 35'(sh);
    if (tot > 35'sd8388607) begin
      res = 24'sh7FFFFF;
    end else if (tot < -35'sd8388608) begin
      res = 24'sh800000;
    end else begin
      res = tot[23:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] abs_diff(logic signed [23:0] a, logic signed [23:0] b);
    logic signed [24:0] d;
    logic signed [24:0] nd;
    d  = 25'(a) - 25'(b);
    nd = -d;
    return d[24] ? nd[23:0] : d[23:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // 1: matrix products, stretch squared, combined radius
    p_xx_q <= $signed(bub_i.cx) * $signed(xf_i.mat_xx);
    p_yx_q <= $signed(bub_i.cy) * $signed(xf_i.mat_yx);
    p_xy_q <= $signed(bub_i.cx) * $signed(xf_i.mat_xy);
    p_yy_q <= $signed(bub_i.cy) * $signed(xf_i.mat_yy);
    s2_1_q <= 32'(bub_i.st) * 32'(bub_i.st);
    r_1_q  <= 24'(bub_i.rad) + 24'(extra_i);
    // 2: mapped centre, radius squared
    cx_q   <= map_axis(p_xx_q, p_yx_q, $signed(xf_i.shift_x));
    cy_q   <= map_axis(p_xy_q, p_yy_q, $signed(xf_i.shift_y));
    s2_2_q <= s2_1_q;
    r2_2_q <= 48'(r_1_q) * 48'(r_1_q);
    // 3: distances
    adx_q  <= abs_diff($signed(px_i), cx_q);
    ady_q  <= abs_diff($signed(py_i), cy_q);
    s2_3_q <= s2_2_q;
    r2_3_q <= r2_2_q;
    // 4: squared distances
    adx2_q   <= 48'(adx_q) * 48'(adx_q);
    ady2_4_q <= 48'(ady_q) * 48'(ady_q);
    s2_4_q   <= s2_3_q;
    r2_4_q   <= r2_3_q;
    // 5: stretch scaling, split into 24-bit halves
    lhi_q    <= 56'(s2_4_q) * 56'(adx2_q[47:24]);
    llo_q    <= 56'(s2_4_q) * 56'(adx2_q[23:0]);
    rhi_q    <= 56'(s2_4_q) * 56'(r2_4_q[47:24]);
    rlo_q    <= 56'(s2_4_q) * 56'(r2_4_q[23:0]);
    ady2_5_q <= ady2_4_q;
    // 6: e^2*dx^2 + dy^2 against e^2*R^2, all scaled by 2^16
    lhs_q <= (81'(lhi_q) << 24) + 81'(llo_q) + (81'(ady2_5_q) << 16);
    rhs_q <= (80'(rhi_q) << 24) + 80'(rlo_q);
    // 7
    hit_q <= lhs_q < 81'(rhs_q);
  end

  assign res_o.valid = v_q[7];
  assign res_o.hit   = hit_q;
  assign res_o.busy  = |v_q;

endmodule

@@ bench/ehit_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehit_tb_pkg
// Word layouts and the scoreboard for the ellipse-set hit test bench. The
// scoreboard keeps its own bubble table and world transform. It predicts the
// answer word for every accepted request word and checks each answer word
// against the oldest prediction.
// ----------------------------------------------------------------------------
package ehit_tb_pkg;

  import ehit_pkg::*;

  localparam int unsigned MaxBubbles = 16;

  // spare request kind: no state change, all-zero answer
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // request word as {tuser, tdata[86:0]}: x in the low bits
  typedef struct packed {
    logic [1:0]          mode;
    logic [StretchW-1:0] st;
    logic [RadiusW-1:0]  rad;
    logic [CoordW-1:0]   y;
    logic [CoordW-1:0]   x;
  } request_t;

  // answer word, m_axis_tdata[6:0]
  typedef struct packed {
    logic           table_full;
    logic [IdW-1:0] bubble_id;
    logic           hit;
  } answer_t;

  function automatic logic [CoordW-1:0] clamp24(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    else if (v < -64'sd8388608) v = -64'sd8388608;
    return CoordW'(v);
  endfunction

  class hit_scoreboard;
    logic [MatW-1:0]     m_xx, m_yx, m_xy, m_yy;
    logic [CoordW-1:0]   sh_x, sh_y;
    bit                  invert_sense;
    bit                  cover_all;
    logic [CoordW-1:0]   tab_x [MaxBubbles];
    logic [CoordW-1:0]   tab_y [MaxBubbles];
    logic [RadiusW-1:0]  tab_r [MaxBubbles];
    logic [StretchW-1:0] tab_s [MaxBubbles];
    int unsigned         count;
    answer_t             answers_due [$];
    int unsigned         failures;

    function new();
      m_xx = 24'h010000;
      m_yx = '0;
      m_xy = '0;
      m_yy = 24'h010000;
      sh_x = '0;
      sh_y = '0;
      invert_sense = 1'b0;
      cover_all = 1'b0;
      count = 0;
      failures = 0;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_MAT_XX:  m_xx = data;
        REG_MAT_YX:  m_yx = data;
        REG_MAT_XY:  m_xy = data;
        REG_MAT_YY:  m_yy = data;
        REG_SHIFT_X: sh_x = data;
        REG_SHIFT_Y: sh_y = data;
        REG_INVERT:  invert_sense = data[0];
        REG_COVER:   cover_all = data[0];
        default: ;
      endcase
    endfunction

    // Q.24 matrix sum, rounded half up to Q.8, then translated and saturated
    function logic [CoordW-1:0] map_axis(logic [CoordW-1:0] px, logic [CoordW-1:0] py,
                                         logic [MatW-1:0] ma, logic [MatW-1:0] mb,
                                         logic [CoordW-1:0] sh);
      longint acc;
      acc = longint'($signed(px)) * longint'($signed(ma))
          + longint'($signed(py)) * longint'($signed(mb));
      acc = ((acc + 64'sd32768) >>> 16) + longint'($signed(sh));
      return clamp24(acc);
    endfunction

    function void centre_of(int unsigned i, output logic [CoordW-1:0] cx,
                            output logic [CoordW-1:0] cy);
      cx = map_axis(tab_x[i], tab_y[i], m_xx, m_yx, sh_x);
      cy = map_axis(tab_x[i], tab_y[i], m_xy, m_yy, sh_y);
    endfunction

    function void note_request(request_t req);
      answer_t           a;
      logic [CoordW-1:0] cx, cy;
      longint            dx, dy;
      logic [127:0]      ux, uy, s2, rr, lhs, rhs;
      bit                covered;
      int unsigned       i;
      a = '0;
      case (req.mode)
        MODE_ADD: begin
          if (count >= MaxBubbles) begin
            a.table_full = 1'b1;
          end else begin
            tab_x[count] = req.x;
            tab_y[count] = req.y;
            tab_r[count] = req.rad;
            tab_s[count] = req.st;
            count++;
            a.bubble_id = IdW'(count);
          end
        end
        MODE_POINT, MODE_DISC: begin
          covered = cover_all;
          for (i = 0; i < count && !covered; i++) begin
            centre_of(i, cx, cy);
            dx = longint'($signed(req.x)) - longint'($signed(cx));
            dy = longint'($signed(req.y)) - longint'($signed(cy));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            ux = 128'(dx);
            uy = 128'(dy);
            s2 = 128'(tab_s[i]) * 128'(tab_s[i]);
            rr = 128'(tab_r[i]);
            if (req.mode == MODE_DISC) rr = rr + 128'(req.rad);
            // s^2*dx^2 + 2^16*dy^2 < s^2*R^2, exact
            lhs = s2 * ux * ux + ((uy * uy) << 16);
            rhs = s2 * rr * rr;
            if (lhs < rhs) covered = 1'b1;
          end
          a.hit = covered ^ invert_sense;
        end
        default: ;
      endcase
      answers_due = {answers_due, a};
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (answers_due.size() == 0) begin
        $error("answer word with nothing pending: %h", got);
        failures++;
        return;
      end
      want = answers_due.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        failures++;
      end
      if (got.bubble_id !== want.bubble_id) begin
        $error("bubble_id: expected %0d, actual %0d", want.bubble_id, got.bubble_id);
        failures++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0d, actual %0d", want.table_full, got.table_full);
        failures++;
      end
    endfunction
  endclass

endpackage

@@ bench/ellipse_set_hit_test_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_set_hit_test_tb
// Drives request words with random gaps against a randomly stalling answer
// side, walks the world transform and the two flags through a set of corner
// and random settings, and checks every answer word against the scoreboard.
// ----------------------------------------------------------------------------
module ellipse_set_hit_test_tb;

  import ehit_pkg::*;
  import ehit_tb_pkg::*;

  localparam int     HalfPeriod  = 4;
  localparam int     WatchLimit  = 4000;
  localparam int     LongHold    = 400;
  localparam int     DrainCycles = 30;
  localparam longint Reach       = 64'sd4194304;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [87:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  hit_scoreboard sb;
  bit            no_idle;
  bit            hold_now;
  int            quiet_cycles;

  ellipse_set_hit_test #(
    .MAX_BUBBLES(MaxBubbles)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // handshake monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.apply_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_request({s_axis_tuser, s_axis_tdata[86:0]});
      if (m_axis_tvalid && m_axis_tready) sb.check_answer(m_axis_tdata[6:0]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // answer side: bursts of ready, short or rare long stalls, a long hold per squeeze phase
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_now) begin
        hold_now = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(12, 1)) @(posedge clk_i);
        m_axis_tready <= 1'b0;
        if ($urandom_range(9, 0) == 0) repeat ($urandom_range(40, 10)) @(posedge clk_i);
        else repeat ($urandom_range(3, 1)) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int unsigned k;
    k = $urandom_range(99, 0);
    if (no_idle || k < 55) return 0;
    if (k < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic request_t mk_req(logic [1:0] mode, logic [CoordW-1:0] x,
                                      logic [CoordW-1:0] y, logic [RadiusW-1:0] rad,
                                      logic [StretchW-1:0] st);
    request_t r;
    r.mode = mode;
    r.x = x;
    r.y = y;
    r.rad = rad;
    r.st = st;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t          r;
    int unsigned       k;
    int unsigned       pick;
    logic [CoordW-1:0] mx, my;
    longint            span_x, span_y;
    k = $urandom_range(99, 0);
    r.x = CoordW'($urandom);
    r.y = CoordW'($urandom);
    r.rad = RadiusW'($urandom);
    r.st = StretchW'($urandom);
    if (k < 12) begin
      r.mode = MODE_ADD;
      // mostly modest bubbles so misses stay common
      if ($urandom_range(15, 0) != 0) r.rad = RadiusW'($urandom_range(65535, 0));
      if ($urandom_range(15, 0) == 0) r.st = '0;
    end else if (k < 15) begin
      r.mode = MODE_SPARE;
    end else begin
      r.mode = (k < 58) ? MODE_POINT : MODE_DISC;
      if (r.mode == MODE_DISC && $urandom_range(3, 0) != 0)
        r.rad = RadiusW'($urandom_range(4095, 0));
      // aim most tests around the mapped outline of a stored bubble
      if (sb.count != 0 && $urandom_range(9, 0) < 7) begin
        pick = $urandom_range(sb.count - 1, 0);
        sb.centre_of(pick, mx, my);
        span_x = longint'(sb.tab_r[pick]) * 2 + 8;
        span_y = ((longint'(sb.tab_r[pick]) * longint'(sb.tab_s[pick])) >>> 8) * 2 + 8;
        if (span_x > Reach) span_x = Reach;
        if (span_y > Reach) span_y = Reach;
        r.x = clamp24(longint'($signed(mx)) + longint'($urandom_range(32'(2 * span_x), 0))
                      - span_x);
        r.y = clamp24(longint'($signed(my)) + longint'($urandom_range(32'(2 * span_y), 0))
                      - span_y);
      end
    end
    return r;
  endfunction

  // valid stays high across back-to-back words
  task automatic send_request(request_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, req.st, req.rad, req.y, req.x};
    s_axis_tuser  <= req.mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic program_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering words and let every pending answer come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.answers_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [MatW-1:0] mxx, logic [MatW-1:0] myx,
                           logic [MatW-1:0] mxy, logic [MatW-1:0] myy,
                           logic [CoordW-1:0] shx, logic [CoordW-1:0] shy,
                           bit inv, bit cov, int n, bit quiet, bit squeeze);
    logic [CfgDataW-1:0] flag_word;
    settle();
    program_reg(REG_MAT_XX, mxx);
    program_reg(REG_MAT_YX, myx);
    program_reg(REG_MAT_XY, mxy);
    program_reg(REG_MAT_YY, myy);
    program_reg(REG_SHIFT_X, shx);
    program_reg(REG_SHIFT_Y, shy);
    // upper bits of the flag registers carry junk
    flag_word = CfgDataW'($urandom);
    flag_word[0] = inv;
    program_reg(REG_INVERT, flag_word);
    flag_word = CfgDataW'($urandom);
    flag_word[0] = cov;
    program_reg(REG_COVER, flag_word);
    no_idle = quiet;
    if (squeeze) hold_now = 1'b1;
    repeat (n) send_request(random_request());
    no_idle = 1'b0;
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    hold_now = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under the reset transform
    send_request(mk_req(MODE_POINT, '0, '0, '0, '0));                // empty table
    send_request(mk_req(MODE_DISC, 24'h7FFFFF, 24'h800000, 23'h7FFFFF, 16'hFFFF));
    send_request(mk_req(MODE_SPARE, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF, 16'hFFFF));
    send_request(mk_req(MODE_ADD, '0, '0, 23'h7FFFFF, 16'h0000));    // zero stretch
    send_request(mk_req(MODE_ADD, 24'h7FFFFF, 24'h7FFFFF, 23'd2560, 16'h0100));
    send_request(mk_req(MODE_ADD, 24'h800000, 24'h800000, 23'd1, 16'hFFFF));
    send_request(mk_req(MODE_ADD, 24'h0003E8, 24'hFFF830, 23'd5000, 16'h0001));
    send_request(mk_req(MODE_POINT, '0, '0, 23'h7FFFFF, 16'h1234));  // radius ignored
    send_request(mk_req(MODE_POINT, 24'h7FFFFF, 24'h7FFFFF, '0, '0));
    send_request(mk_req(MODE_POINT, 24'h800000, 24'h800000, '0, '0));
    send_request(mk_req(MODE_POINT, 24'h7FFFFF - 24'd2559, 24'h7FFFFF, '0, '0));
    send_request(mk_req(MODE_POINT, 24'h7FFFFF - 24'd2560, 24'h7FFFFF, '0, '0)); // on edge
    send_request(mk_req(MODE_DISC, '0, '0, 23'h7FFFFF, '0));
    send_request(mk_req(MODE_DISC, '0, '0, '0, '0));
    send_request(mk_req(MODE_DISC, 24'h7FFFFF - 24'd2570, 24'h7FFFFF, 23'd10, '0));
    send_request(mk_req(MODE_DISC, 24'h7FFFFF - 24'd2570, 24'h7FFFFF, 23'd11, '0));
    send_request(mk_req(MODE_POINT, 24'h0003E8, 24'hFFF830 + 24'd19, '0, '0));
    send_request(mk_req(MODE_POINT, 24'h0003E8, 24'hFFF830 + 24'd20, '0, '0));
    send_request(mk_req(MODE_SPARE, '0, '0, '0, '0));
    send_request(mk_req(MODE_ADD, 24'h01E240, 24'hF60C0F, 23'd0, 16'd300)); // zero radius

    run_phase(24'h010000, 24'h000000, 24'h000000, 24'h010000, 24'h000000, 24'h000000,
              1'b0, 1'b0, 90, 1'b0, 1'b0);
    run_phase(24'h00B505, 24'hFF4AFB, 24'h00B505, 24'h00B505, 24'h001000, 24'hFFE000,
              1'b0, 1'b0, 90, 1'b0, 1'b1);
    run_phase(24'h010000, 24'h000000, 24'h000000, 24'h010000, 24'h7FFFFF, 24'h800000,
              1'b1, 1'b0, 90, 1'b1, 1'b0);
    run_phase(24'h010000, 24'h000000, 24'h000000, 24'h010000, 24'h000000, 24'h000000,
              1'b0, 1'b1, 50, 1'b0, 1'b0);
    run_phase(24'h010000, 24'h000000, 24'h000000, 24'h010000, 24'h000000, 24'h000000,
              1'b1, 1'b1, 50, 1'b0, 1'b0);
    run_phase(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
              1'b0, 1'b0, 80, 1'b0, 1'b0);
    run_phase(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
              1'b0, 1'b0, 80, 1'b0, 1'b0);
    run_phase(MatW'($urandom), MatW'($urandom), MatW'($urandom), MatW'($urandom),
              CoordW'($urandom), CoordW'($urandom), 1'($urandom), 1'b0, 90, 1'b0, 1'b1);
    run_phase(24'h000000, 24'h000000, 24'h000000, 24'h000000,
              CoordW'($urandom), CoordW'($urandom), 1'b0, 1'b0, 80, 1'b0, 1'b0);
    run_phase(24'h020000, 24'h000000, 24'h000000, 24'h020000, 24'h000000, 24'h000000,
              1'($urandom), 1'b0, 90, 1'b0, 1'b0);
    run_phase(MatW'($urandom), MatW'($urandom), MatW'($urandom), MatW'($urandom),
              CoordW'($urandom), CoordW'($urandom), 1'($urandom), 1'b0, 90, 1'b0, 1'b0);

    settle();
    if (sb.failures == 0 && sb.answers_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ehit_pkg.sv
src/ehit_cell.sv
src/ehit_eval.sv
src/ellipse_set_hit_test.sv
bench/ehit_tb_pkg.sv
bench/ellipse_set_hit_test_tb.sv
